/* rtl/mca_pkg.sv */
// Shared types and codes for the MESI cache-agent controller.
`timescale 1ns / 1ps
`default_nettype none

package mca_pkg;

  // Event codes carried in func.
  typedef enum logic [2:0] {
    FN_LOAD    = 3'd0,
    FN_STORE   = 3'd1,
    FN_REPLACE = 3'd2,
    FN_FWD_GETS = 3'd3,
    FN_FWD_GETM = 3'd4,
    FN_INV     = 3'd5,
    FN_PUT_ACK = 3'd6,
    FN_DATA    = 3'd7
  } mca_func_e;

  // Line states; codes 13 to 15 are not states and are flagged as errors.
  typedef enum logic [3:0] {
    ST_I     = 4'd0,
    ST_S     = 4'd1,
    ST_E     = 4'd2,
    ST_M     = 4'd3,
    ST_IS_D  = 4'd4,
    ST_IM_AD = 4'd5,
    ST_IM_A  = 4'd6,
    ST_SM_AD = 4'd7,
    ST_SM_A  = 4'd8,
    ST_MI_A  = 4'd9,
    ST_EI_A  = 4'd10,
    ST_SI_A  = 4'd11,
    ST_II_A  = 4'd12
  } mca_state_e;

  // Result codes.
  typedef enum logic [2:0] {
    RES_NONE     = 3'd0,
    RES_HIT      = 3'd1,
    RES_MISS     = 3'd2,
    RES_BLOCKED  = 3'd3,
    RES_CONSUMED = 3'd4,
    RES_STALL    = 3'd5,
    RES_COMMIT   = 3'd6
  } mca_result_e;

  // Bit positions in the command mask.
  localparam int unsigned CmdW      = 11;
  localparam int unsigned CmdGetS   = 0;
  localparam int unsigned CmdGetM   = 1;
  localparam int unsigned CmdPutS   = 2;
  localparam int unsigned CmdPutM   = 3;
  localparam int unsigned CmdPutE   = 4;
  localparam int unsigned CmdD2Dir  = 5;
  localparam int unsigned CmdD2Req  = 6;
  localparam int unsigned CmdInvAck = 7;
  localparam int unsigned CmdUpd    = 8;
  localparam int unsigned CmdIncAck = 9;
  localparam int unsigned CmdSetAck = 10;

  // One incoming event with the line's state.
  typedef struct packed {
    logic [2:0] func;
    logic [3:0] line_state;
    logic       inv_is_ack;
    logic       last_inv_ack;
    logic       src_is_directory;
    logic       data_exclusive;
    logic [3:0] ack_count_in;
  } mca_event_t;

  // The decision for one event.
  typedef struct packed {
    logic [CmdW-1:0] commands;
    logic [3:0]      next_state;
    logic [2:0]      result_code;
    logic            error_flag;
    logic [3:0]      ack_expect;
    logic            transaction_done;
    logic            state_is_stable;
  } mca_verdict_t;

endpackage

`default_nettype wire

/* rtl/mca_decode.sv */
// Combinational MESI transition table for one event on one line.
`timescale 1ns / 1ps
`default_nettype none

module mca_decode import mca_pkg::*; (
  input  mca_event_t   ev_i,
  output mca_verdict_t vd_o
);

  logic [3:0] s;
  logic       getm;

  assign s    = ev_i.line_state;
  assign getm = (ev_i.func == FN_FWD_GETM);

  // Decode the event against the current state.
  always_comb begin
    vd_o                  = '0;
    vd_o.next_state       = s;
    vd_o.result_code      = RES_NONE;
    vd_o.state_is_stable  = (s <= ST_M);

    if (s > ST_II_A) begin
      vd_o.error_flag = 1'b1;
    end else begin
      case (ev_i.func)
        FN_LOAD: begin
          if (s == ST_I) begin
            vd_o.commands[CmdGetS] = 1'b1;
            vd_o.commands[CmdUpd]  = 1'b1;
            vd_o.next_state        = ST_IS_D;
            vd_o.result_code       = RES_MISS;
          end else if (s == ST_S || s == ST_E || s == ST_M || s == ST_SM_AD ||
                       s == ST_SM_A) begin
            vd_o.result_code = RES_HIT;
          end else begin
            vd_o.result_code = RES_BLOCKED;
          end
        end
        FN_STORE: begin
          if (s == ST_I) begin
            vd_o.commands[CmdGetM] = 1'b1;
            vd_o.commands[CmdUpd]  = 1'b1;
            vd_o.next_state        = ST_IM_AD;
            vd_o.result_code       = RES_MISS;
          end else if (s == ST_S) begin
            // Upgrade from shared reports no result code.
            vd_o.commands[CmdGetM] = 1'b1;
            vd_o.commands[CmdUpd]  = 1'b1;
            vd_o.next_state        = ST_SM_AD;
          end else if (s == ST_E) begin
            vd_o.commands[CmdUpd] = 1'b1;
            vd_o.next_state       = ST_M;
            vd_o.result_code      = RES_HIT;
          end else if (s == ST_M) begin
            vd_o.result_code = RES_HIT;
          end else begin
            vd_o.result_code = RES_MISS;
          end
        end
        FN_REPLACE: begin
          if (s == ST_S) begin
            vd_o.commands[CmdPutS] = 1'b1;
            vd_o.commands[CmdUpd]  = 1'b1;
            vd_o.next_state        = ST_SI_A;
            vd_o.result_code       = RES_CONSUMED;
          end else if (s == ST_M) begin
            vd_o.commands[CmdPutM]  = 1'b1;
            vd_o.commands[CmdD2Dir] = 1'b1;
            vd_o.commands[CmdUpd]   = 1'b1;
            vd_o.next_state         = ST_MI_A;
            vd_o.result_code        = RES_CONSUMED;
          end else if (s == ST_E) begin
            vd_o.commands[CmdPutE] = 1'b1;
            vd_o.commands[CmdUpd]  = 1'b1;
            vd_o.next_state        = ST_EI_A;
            vd_o.result_code       = RES_CONSUMED;
          end else if (s >= ST_IS_D) begin
            vd_o.result_code = RES_BLOCKED;
          end else begin
            vd_o.error_flag = 1'b1;
          end
        end
        FN_FWD_GETS, FN_FWD_GETM: begin
          if (s == ST_IM_AD || s == ST_IM_A || s == ST_SM_AD || s == ST_SM_A) begin
            vd_o.result_code = RES_STALL;
          end else if (s == ST_M || s == ST_E) begin
            vd_o.commands[CmdD2Req] = 1'b1;
            vd_o.commands[CmdD2Dir] = !getm;
            vd_o.commands[CmdUpd]   = 1'b1;
            vd_o.next_state         = getm ? ST_I : ST_S;
            vd_o.result_code        = RES_COMMIT;
          end else if (s == ST_MI_A || s == ST_EI_A) begin
            vd_o.commands[CmdD2Req] = 1'b1;
            vd_o.commands[CmdD2Dir] = !getm;
            vd_o.commands[CmdUpd]   = 1'b1;
            vd_o.next_state         = getm ? ST_II_A : ST_SI_A;
            vd_o.result_code        = RES_COMMIT;
          end else begin
            vd_o.error_flag = 1'b1;
          end
        end
        FN_INV: begin
          if (ev_i.inv_is_ack) begin
            // Every ack counts; the last one completes the upgrade.
            vd_o.commands[CmdIncAck] = 1'b1;
            if (ev_i.last_inv_ack) begin
              if (s == ST_IM_A || s == ST_SM_A) begin
                vd_o.commands[CmdUpd] = 1'b1;
                vd_o.next_state       = ST_M;
                vd_o.result_code      = RES_COMMIT;
              end else begin
                vd_o.error_flag = 1'b1;
              end
            end
          end else if (s == ST_IS_D) begin
            vd_o.result_code = RES_STALL;
          end else if (s == ST_S || s == ST_SM_AD || s == ST_SI_A) begin
            vd_o.commands[CmdInvAck] = 1'b1;
            vd_o.commands[CmdUpd]    = 1'b1;
            vd_o.result_code         = RES_COMMIT;
            if (s == ST_S) begin
              vd_o.next_state = ST_I;
            end else if (s == ST_SM_AD) begin
              vd_o.next_state = ST_IM_AD;
            end else begin
              vd_o.next_state = ST_II_A;
            end
          end else begin
            vd_o.error_flag = 1'b1;
          end
        end
        FN_PUT_ACK: begin
          if (s == ST_MI_A || s == ST_EI_A || s == ST_SI_A || s == ST_II_A) begin
            vd_o.commands[CmdUpd] = 1'b1;
            vd_o.next_state       = ST_I;
            vd_o.result_code      = RES_COMMIT;
          end else begin
            vd_o.error_flag = 1'b1;
          end
        end
        default: begin
          // Data message.
          if (ev_i.src_is_directory && ev_i.data_exclusive) begin
            if (s == ST_IS_D) begin
              vd_o.commands[CmdUpd]  = 1'b1;
              vd_o.next_state        = ST_E;
              vd_o.result_code       = RES_COMMIT;
              vd_o.transaction_done  = 1'b1;
            end else begin
              vd_o.error_flag = 1'b1;
            end
          end else if (!ev_i.src_is_directory || ev_i.ack_count_in == 4'd0) begin
            if (s == ST_IS_D) begin
              vd_o.commands[CmdUpd]  = 1'b1;
              vd_o.next_state        = ST_S;
              vd_o.result_code       = RES_COMMIT;
              vd_o.transaction_done  = 1'b1;
            end else if (s == ST_IM_AD || s == ST_SM_AD) begin
              vd_o.commands[CmdUpd]  = 1'b1;
              vd_o.next_state        = ST_M;
              vd_o.result_code       = RES_COMMIT;
              vd_o.transaction_done  = 1'b1;
            end else begin
              vd_o.error_flag = 1'b1;
            end
          end else begin
            // Counted directory data: the ack count is reported even on error.
            vd_o.commands[CmdSetAck] = 1'b1;
            vd_o.ack_expect          = ev_i.ack_count_in;
            if (s == ST_IM_AD) begin
              vd_o.commands[CmdUpd] = 1'b1;
              vd_o.next_state       = ST_IM_A;
              vd_o.result_code      = RES_COMMIT;
            end else if (s == ST_SM_AD) begin
              vd_o.commands[CmdUpd] = 1'b1;
              vd_o.next_state       = ST_SM_A;
              vd_o.result_code      = RES_COMMIT;
            end else begin
              vd_o.error_flag = 1'b1;
            end
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/mesi_cache_agent_controller.sv */
// Top level of the MESI cache-agent controller: input register, decode, result register.
`timescale 1ns / 1ps
`default_nettype none

// MESI cache-agent controller. Each transaction presents one event (core load,
// store or replacement, or a coherence message) with the line's current state,
// and yields exactly one result: command mask, next state, result code, error
// flag, expected ack count and done flag, plus a stable-state indication. The
// block is a two-register pipeline around a single-pass transition table. An
// accepted transaction is held in the input register, decoded by the table and
// captured in the result register once the output advances. A new transaction
// is accepted every cycle while the output is not stalled. Both channels use
// valid and stall. The input stalls only when both pipeline registers hold a
// transaction and the output is stalled.

module mesi_cache_agent_controller import mca_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [2:0]      func_i,
  input  wire logic [3:0]      line_state_i,
  input  wire logic            inv_is_ack_i,
  input  wire logic            last_inv_ack_i,
  input  wire logic            src_is_directory_i,
  input  wire logic            data_exclusive_i,
  input  wire logic [3:0]      ack_count_in_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [CmdW-1:0]      commands_o,
  output logic [3:0]           next_state_o,
  output logic [2:0]           result_code_o,
  output logic                 error_flag_o,
  output logic [3:0]           ack_expect_o,
  output logic                 transaction_done_o,
  output logic                 state_is_stable_o
);

  logic         in_valid_q, in_valid_d;
  mca_event_t   ev_q, ev_d;
  logic         out_valid_q, out_valid_d;
  mca_verdict_t vd_q, vd_d, vd_comb;
  logic         out_adv;
  logic         in_take;

  // Pipeline flow control.
  assign out_adv    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !out_adv;
  assign in_take    = in_valid_i && !in_stall_o;

  // Transition table.
  mca_decode u_decode (
    .ev_i (ev_q),
    .vd_o (vd_comb)
  );

  // Next values of both pipeline registers.
  always_comb begin
    in_valid_d  = in_stall_o ? in_valid_q : in_valid_i;
    ev_d        = ev_q;
    if (in_take) begin
      ev_d.func             = func_i;
      ev_d.line_state       = line_state_i;
      ev_d.inv_is_ack       = inv_is_ack_i;
      ev_d.last_inv_ack     = last_inv_ack_i;
      ev_d.src_is_directory = src_is_directory_i;
      ev_d.data_exclusive   = data_exclusive_i;
      ev_d.ack_count_in     = ack_count_in_i;
    end
    out_valid_d = out_adv ? in_valid_q : out_valid_q;
    vd_d        = (out_adv && in_valid_q) ? vd_comb : vd_q;
  end

  // Valid bits take reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ev_q <= ev_d;
    vd_q <= vd_d;
  end

  // Output ports.
  assign out_valid_o        = out_valid_q;
  assign commands_o         = vd_q.commands;
  assign next_state_o       = vd_q.next_state;
  assign result_code_o      = vd_q.result_code;
  assign error_flag_o       = vd_q.error_flag;
  assign ack_expect_o       = vd_q.ack_expect;
  assign transaction_done_o = vd_q.transaction_done;
  assign state_is_stable_o  = vd_q.state_is_stable;

  // An illegal event never carries a result code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && vd_q.error_flag |-> vd_q.result_code == RES_NONE)
    else $error("error result carries a result code");

  // A completed transaction always commits a state update.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && vd_q.transaction_done |->
      vd_q.commands[CmdUpd] && vd_q.result_code == RES_COMMIT)
    else $error("transaction done without a committed update");

  // A nonzero ack count is only reported with SetAckExpect.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && vd_q.ack_expect != 4'd0 |-> vd_q.commands[CmdSetAck])
    else $error("ack count without SetAckExpect");

  // A held input transaction is not dropped while the output is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_adv |=> in_valid_q && $stable(ev_q))
    else $error("input register lost a stalled transaction");

endmodule

`default_nettype wire
